// ===== src/lcp_pkg.sv =====
// Shared types, constants and reset tables for the colour palette block.
package lcp_pkg;

  localparam int COLOR_W       = 24;
  localparam int SLOT_W        = 5;
  localparam int RANK_W        = 5;

  typedef logic [COLOR_W-1:0] color_t;
  typedef logic [SLOT_W-1:0]  slot_t;
  typedef logic [RANK_W-1:0]  rank_t;

  localparam logic KIND_SELECT = 1'b0;
  localparam logic KIND_COLOR  = 1'b1;

  typedef struct packed {
    logic capture;
    logic lookup;
    logic update;
  } lcp_cmd_t;

  typedef struct packed {
    logic out_free;
  } lcp_sts_t;

  // Default palette, red in the low byte; entries past the list are black.
  function automatic color_t default_color(input int idx);
    color_t c;
    begin
      unique case (idx)
        0:       c = 24'h000000;
        1:       c = 24'h000080;
        2:       c = 24'h008000;
        3:       c = 24'h008080;
        4:       c = 24'h800000;
        5:       c = 24'h800080;
        6:       c = 24'h808000;
        7:       c = 24'hC0C0C0;
        8:       c = 24'hC0DCC0;
        9:       c = 24'hF0CAA6;
        10:      c = 24'hF0FBFF;
        11:      c = 24'hA4A0A0;
        12:      c = 24'h808080;
        13:      c = 24'h0000FF;
        14:      c = 24'h00FF00;
        15:      c = 24'h00FFFF;
        16:      c = 24'hFF0000;
        17:      c = 24'hFF00FF;
        18:      c = 24'hFFFF00;
        19:      c = 24'hFFFFFF;
        default: c = '0;
      endcase
      return c;
    end
  endfunction

  // Centre slots start oldest, end slots start newest.
  function automatic rank_t reset_rank(input int idx, input int entries);
    int r;
    begin
      if (idx < (entries + 1) / 2) begin
        r = 2 * idx + 1;
      end else begin
        r = 2 * (entries - idx);
      end
      return r[RANK_W-1:0];
    end
  endfunction

endpackage

// ===== src/lcp_ctrl.sv =====
// Sequencer for the palette block: capture, lookup and update steps.
module lcp_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  lcp_pkg::lcp_sts_t sts,
  output lcp_pkg::lcp_cmd_t cmd
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_LOOKUP,
    S_UPDATE
  } state_t;

  state_t state;
  logic   accept;
  logic   update_go;

  assign update_go = (state == S_UPDATE) && sts.out_free;
  assign in_stall  = !((state == S_IDLE) || update_go);
  assign accept    = in_valid && !in_stall;

  assign cmd.capture = accept;
  assign cmd.lookup  = (state == S_LOOKUP);
  assign cmd.update  = update_go;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (accept) state <= S_LOOKUP;
        end
        S_LOOKUP: begin
          state <= S_UPDATE;
        end
        S_UPDATE: begin
          // hold until the output register can take the word
          if (update_go) state <= accept ? S_LOOKUP : S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== src/lcp_dpath.sv =====
// Palette and rank registers, search logic and output register.
module lcp_dpath #(
  parameter int ENTRIES = 20
) (
  input  logic                   clk,
  input  logic                   rst,
  input  lcp_pkg::lcp_cmd_t      cmd,
  output lcp_pkg::lcp_sts_t      sts,
  input  logic                   kind,
  input  lcp_pkg::slot_t         slot_index,
  input  lcp_pkg::color_t        color_value,
  output logic                   out_valid,
  input  logic                   out_stall,
  output lcp_pkg::slot_t         chosen_slot,
  output logic                   was_hit,
  output lcp_pkg::color_t        slot_color
);

  localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam lcp_pkg::rank_t LAST_RANK = lcp_pkg::RANK_W'(ENTRIES);
  localparam lcp_pkg::slot_t SLOT_LIMIT = lcp_pkg::SLOT_W'(ENTRIES);

  lcp_pkg::color_t palette [ENTRIES];
  lcp_pkg::rank_t  rank    [ENTRIES];

  logic            kind_q;
  lcp_pkg::slot_t  sel_q;
  lcp_pkg::color_t color_q;

  lcp_pkg::slot_t  slot_q;
  logic            hit_q;
  logic            miss_q;
  logic            in_range_q;

  lcp_pkg::slot_t  match_slot;
  logic            match_found;
  lcp_pkg::slot_t  victim_slot;
  logic [IDX_W-1:0] idx;
  lcp_pkg::rank_t  cur_rank;
  lcp_pkg::color_t new_color;

  // Lowest matching slot wins; scan from the top so lower indices overwrite.
  always_comb begin
    match_slot  = '0;
    match_found = 1'b0;
    victim_slot = '0;
    for (int i = ENTRIES - 1; i >= 0; i--) begin
      if (palette[i] == color_q) begin
        match_slot  = lcp_pkg::SLOT_W'(i);
        match_found = 1'b1;
      end
      if (rank[i] == LAST_RANK) begin
        victim_slot = lcp_pkg::SLOT_W'(i);
      end
    end
  end

  assign idx      = slot_q[IDX_W-1:0];
  assign cur_rank = in_range_q ? rank[idx] : '0;

  always_comb begin
    if (!in_range_q) begin
      new_color = '0;
    end else if (miss_q) begin
      new_color = color_q;
    end else begin
      new_color = palette[idx];
    end
  end

  assign sts.out_free = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      kind_q  <= kind;
      sel_q   <= slot_index;
      color_q <= color_value;
    end
    if (cmd.lookup) begin
      if (kind_q == lcp_pkg::KIND_SELECT) begin
        slot_q     <= sel_q;
        hit_q      <= (sel_q < SLOT_LIMIT);
        in_range_q <= (sel_q < SLOT_LIMIT);
        miss_q     <= 1'b0;
      end else begin
        slot_q     <= match_found ? match_slot : victim_slot;
        hit_q      <= match_found;
        in_range_q <= 1'b1;
        miss_q     <= !match_found;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < ENTRIES; i++) begin
        palette[i] <= lcp_pkg::default_color(i);
        rank[i]    <= lcp_pkg::reset_rank(i, ENTRIES);
      end
    end else if (cmd.update && in_range_q) begin
      for (int i = 0; i < ENTRIES; i++) begin
        if (slot_q == lcp_pkg::SLOT_W'(i)) begin
          rank[i] <= lcp_pkg::RANK_W'(1);
          if (miss_q) palette[i] <= color_q;
        end else if (cur_rank > rank[i]) begin
          // age every entry that was more recent than the chosen one
          rank[i] <= rank[i] + lcp_pkg::RANK_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.update) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.update) begin
      chosen_slot <= slot_q;
      was_hit     <= hit_q;
      slot_color  <= new_color;
    end
  end

endmodule

// ===== src/lru_color_palette.sv =====
// Top level of the LRU colour palette: sequencer plus datapath.
//
//   channel | direction | handshake          | word
//   in      | receive   | in_valid/in_stall   | kind, slot_index, color_value
//   out     | send      | out_valid/out_stall | chosen_slot, was_hit, slot_color
//
// After an item is accepted, the lookup step compares its colour with every entry
// and finds the oldest rank; the update step shifts the ranks and writes the entry.
// A select word uses its slot index instead. A new word is taken in idle or in the
// update step, never during lookup. Reset loads the default palette and rank order.
// The update cycle waits while a previous result sits unread under out_stall.
module lru_color_palette #(
  parameter int ENTRIES = 20
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_stall,
  input  logic            kind,
  input  lcp_pkg::slot_t  slot_index,
  input  lcp_pkg::color_t color_value,
  output logic            out_valid,
  input  logic            out_stall,
  output lcp_pkg::slot_t  chosen_slot,
  output logic            was_hit,
  output lcp_pkg::color_t slot_color
);

  lcp_pkg::lcp_cmd_t cmd;
  lcp_pkg::lcp_sts_t sts;

  lcp_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  lcp_dpath #(
    .ENTRIES (ENTRIES)
  ) u_dpath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .sts         (sts),
    .kind        (kind),
    .slot_index  (slot_index),
    .color_value (color_value),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .chosen_slot (chosen_slot),
    .was_hit     (was_hit),
    .slot_color  (slot_color)
  );

`ifndef SYNTHESIS
  a_accept_then_lookup: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> cmd.lookup)
    else $error("accepted word not followed by lookup");

  a_lookup_blocks_input: assert property (@(posedge clk) disable iff (rst)
    cmd.lookup |-> (in_stall && !cmd.update))
    else $error("input taken during lookup");

  a_update_gives_result: assert property (@(posedge clk) disable iff (rst)
    cmd.update |=> out_valid)
    else $error("update without result");

  a_lookup_then_update_step: assert property (@(posedge clk) disable iff (rst)
    cmd.lookup |=> !cmd.lookup)
    else $error("lookup repeated");
`endif

endmodule
